>>> src/llas_pkg.sv
// Shared types, constants and helpers for the life-like automaton step block.
// Used by llas_rule and life_like_automaton_step; no dependencies.
package llas_pkg;

    localparam int MAX_ROWS = 64;
    localparam int MAX_COLS = 64;
    localparam int ROW_W    = $clog2(MAX_ROWS);
    localparam int COL_W    = $clog2(MAX_COLS);
    localparam int SIZE_W   = 7;
    localparam int MASK_W   = 9;
    localparam int CFG_W    = 9;
    localparam int CNT_W    = 4;

    typedef logic [MAX_COLS-1:0] row_t;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_GEN   = 2'd1,
        OP_READ  = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        CFG_ROWS    = 2'd0,
        CFG_COLS    = 2'd1,
        CFG_BIRTH   = 2'd2,
        CFG_SURVIVE = 2'd3
    } cfg_idx_t;

    localparam logic [SIZE_W-1:0] ROWS_RST    = SIZE_W'(64);
    localparam logic [SIZE_W-1:0] COLS_RST    = SIZE_W'(64);
    localparam logic [MASK_W-1:0] BIRTH_RST   = MASK_W'(8);
    localparam logic [MASK_W-1:0] SURVIVE_RST = MASK_W'(12);

    // Three old rows around the row being updated.
    typedef struct packed {
        row_t above;
        row_t middle;
        row_t below;
    } nbhd_t;

    typedef struct packed {
        logic [MASK_W-1:0] birth;
        logic [MASK_W-1:0] survive;
    } rule_mask_t;

    // A size of zero acts as one; sizes beyond the storage saturate.
    function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] v,
                                                   input logic [SIZE_W-1:0] lim);
        logic [SIZE_W-1:0] r;
        if (v == '0)
            r = SIZE_W'(1);
        else if (v > lim)
            r = lim;
        else
            r = v;
        return r;
    endfunction

endpackage

>>> src/life_like_automaton_step.sv
// Top level of the life-like automaton step: sequencer, row buffers, output register.
// Depends on llas_pkg, llas_ram and llas_rule.
//
//   channel | signals                                   | direction
//   --------+-------------------------------------------+----------
//   in      | in_valid, in_ready, operation, row, col,  | in
//           | cell_value                                |
//   out     | out_valid, out_ready, cell_alive, status  | out
//   cfg     | cfg_we, cfg_index, cfg_data               | in
//
// A cell write or read in range passes through a read step and a modify step before the result step.
// A generation loads the top, middle and bottom rows, then updates the grid
// one cell per cycle through the shared rule unit, with a row write-back after each
// row and a row-buffer shift between rows on the single grid RAM.
// Reset leaves every row marked empty, so the grid reads as all dead at once.
// in_ready is low while an item is in work; a waiting result beat holds the sequencer.
module life_like_automaton_step (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [1:0]                  operation,
    input  logic [llas_pkg::ROW_W-1:0]  row,
    input  logic [llas_pkg::COL_W-1:0]  col,
    input  logic                        cell_value,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        cell_alive,
    output logic                        status,
    input  logic                        cfg_we,
    input  logic [1:0]                  cfg_index,
    input  logic [llas_pkg::CFG_W-1:0]  cfg_data
);
    import llas_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE    = 11'b000_0000_0001,
        S_C_RD    = 11'b000_0000_0010,
        S_C_MOD   = 11'b000_0000_0100,
        S_G_TOP   = 11'b000_0000_1000,
        S_G_MID   = 11'b000_0001_0000,
        S_G_BOT   = 11'b000_0010_0000,
        S_G_LOAD  = 11'b000_0100_0000,
        S_G_CELL  = 11'b000_1000_0000,
        S_G_WR    = 11'b001_0000_0000,
        S_G_SHIFT = 11'b010_0000_0000,
        S_RESP    = 11'b100_0000_0000
    } state_t;

    state_t            state_reg, state_next;
    logic [SIZE_W-1:0] rows_reg, rows_next;
    logic [SIZE_W-1:0] cols_reg, cols_next;
    logic [MASK_W-1:0] birth_reg, birth_next;
    logic [MASK_W-1:0] survive_reg, survive_next;
    logic [MAX_ROWS-1:0] row_valid_reg, row_valid_next;
    logic              rd_valid_reg;
    logic              out_valid_reg, out_valid_next;

    op_t               op_reg, op_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic              val_reg, val_next;
    logic [ROW_W-1:0]  row_cnt_reg, row_cnt_next;
    logic [COL_W-1:0]  col_cnt_reg, col_cnt_next;
    row_t              above_reg, above_next;
    row_t              middle_reg, middle_next;
    row_t              below_reg, below_next;
    row_t              first_reg, first_next;
    row_t              new_reg, new_next;
    logic              res_alive_reg, res_alive_next;
    logic              res_status_reg, res_status_next;
    logic              alive_out_reg, alive_out_next;
    logic              status_out_reg, status_out_next;

    logic [SIZE_W-1:0] nr;
    logic [SIZE_W-1:0] nc;
    logic              ram_we;
    logic [ROW_W-1:0]  ram_waddr;
    row_t              ram_wdata;
    logic [ROW_W-1:0]  ram_raddr;
    row_t              ram_rdata;
    row_t              row_data;
    logic              rule_alive;
    logic              in_beat;
    logic              in_range;
    nbhd_t             nbhd;
    rule_mask_t        masks;
    logic [SIZE_W-1:0] row_cnt_ext;

    assign nr          = eff_size(rows_reg, SIZE_W'(MAX_ROWS));
    assign nc          = eff_size(cols_reg, SIZE_W'(MAX_COLS));
    assign in_ready    = (state_reg == S_IDLE);
    assign in_beat     = in_valid && in_ready;
    assign in_range    = (SIZE_W'(row) < nr) && (SIZE_W'(col) < nc);
    assign row_data    = rd_valid_reg ? ram_rdata : '0;
    assign row_cnt_ext = SIZE_W'(row_cnt_reg);

    assign nbhd.above  = above_reg;
    assign nbhd.middle = middle_reg;
    assign nbhd.below  = below_reg;
    assign masks.birth   = birth_reg;
    assign masks.survive = survive_reg;

    llas_ram #(
        .WIDTH (MAX_COLS),
        .DEPTH (MAX_ROWS)
    ) u_grid (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    llas_rule u_rule (
        .rows       (nbhd),
        .col        (col_cnt_reg),
        .ncols      (nc),
        .masks      (masks),
        .next_alive (rule_alive)
    );

    // Read address per sequencer step.
    always_comb
    begin
        unique case (state_reg)
            S_C_RD:  ram_raddr = row_reg;
            S_G_TOP: ram_raddr = ROW_W'(nr - SIZE_W'(1));
            S_G_MID: ram_raddr = '0;
            S_G_BOT: ram_raddr = (nr == SIZE_W'(1)) ? '0 : ROW_W'(1);
            S_G_WR:  ram_raddr = ROW_W'(row_cnt_ext + SIZE_W'(2));
            default: ram_raddr = row_reg;
        endcase
    end

    // Write port: read-modify-write of one cell, or a finished generation row.
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = row_reg;
        ram_wdata = row_data;
        if (state_reg == S_C_MOD)
        begin
            ram_we           = (op_reg == OP_WRITE);
            ram_wdata[col_reg] = val_reg;
        end
        else if (state_reg == S_G_WR)
        begin
            ram_we    = 1'b1;
            ram_waddr = row_cnt_reg;
            ram_wdata = new_reg;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        rows_next       = rows_reg;
        cols_next       = cols_reg;
        birth_next      = birth_reg;
        survive_next    = survive_reg;
        row_valid_next  = row_valid_reg;
        out_valid_next  = out_valid_reg;
        op_next         = op_reg;
        row_next        = row_reg;
        col_next        = col_reg;
        val_next        = val_reg;
        row_cnt_next    = row_cnt_reg;
        col_cnt_next    = col_cnt_reg;
        above_next      = above_reg;
        middle_next     = middle_reg;
        below_next      = below_reg;
        first_next      = first_reg;
        new_next        = new_reg;
        res_alive_next  = res_alive_reg;
        res_status_next = res_status_reg;
        alive_out_next  = alive_out_reg;
        status_out_next = status_out_reg;

        if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_ROWS:    rows_next    = cfg_data[SIZE_W-1:0];
                CFG_COLS:    cols_next    = cfg_data[SIZE_W-1:0];
                CFG_BIRTH:   birth_next   = cfg_data[MASK_W-1:0];
                CFG_SURVIVE: survive_next = cfg_data[MASK_W-1:0];
                default:     rows_next    = rows_reg;
            endcase
        end

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (ram_we)
        begin
            row_valid_next[ram_waddr] = 1'b1;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_beat)
                begin
                    op_next         = op_t'(operation);
                    row_next        = row;
                    col_next        = col;
                    val_next        = cell_value;
                    res_alive_next  = 1'b0;
                    res_status_next = 1'b0;
                    unique case (op_t'(operation))
                        OP_GEN:
                        begin
                            state_next = S_G_TOP;
                        end
                        OP_WRITE, OP_READ:
                        begin
                            if (in_range)
                            begin
                                state_next = S_C_RD;
                            end
                            else
                            begin
                                res_status_next = 1'b1;
                                state_next      = S_RESP;
                            end
                        end
                        default:
                        begin
                            state_next = S_RESP;
                        end
                    endcase
                end
            end
            S_C_RD:
            begin
                state_next = S_C_MOD;
            end
            S_C_MOD:
            begin
                if (op_reg == OP_READ)
                begin
                    res_alive_next = row_data[col_reg];
                end
                state_next = S_RESP;
            end
            S_G_TOP:
            begin
                state_next = S_G_MID;
            end
            S_G_MID:
            begin
                above_next = row_data;
                state_next = S_G_BOT;
            end
            S_G_BOT:
            begin
                middle_next = row_data;
                first_next  = row_data;
                new_next    = row_data;
                state_next  = S_G_LOAD;
            end
            S_G_LOAD:
            begin
                below_next   = row_data;
                row_cnt_next = '0;
                col_cnt_next = '0;
                state_next   = S_G_CELL;
            end
            S_G_CELL:
            begin
                new_next[col_cnt_reg] = rule_alive;
                if (SIZE_W'(col_cnt_reg) == nc - SIZE_W'(1))
                begin
                    state_next = S_G_WR;
                end
                else
                begin
                    col_cnt_next = col_cnt_reg + COL_W'(1);
                end
            end
            S_G_WR:
            begin
                if (row_cnt_ext == nr - SIZE_W'(1))
                begin
                    state_next = S_RESP;
                end
                else
                begin
                    row_cnt_next = row_cnt_reg + ROW_W'(1);
                    state_next   = S_G_SHIFT;
                end
            end
            S_G_SHIFT:
            begin
                // The last row wraps to the saved old copy of row zero.
                above_next   = middle_reg;
                middle_next  = below_reg;
                new_next     = below_reg;
                below_next   = (row_cnt_ext + SIZE_W'(1) < nr) ? row_data : first_reg;
                col_cnt_next = '0;
                state_next   = S_G_CELL;
            end
            S_RESP:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    alive_out_next  = res_alive_reg;
                    status_out_next = res_status_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rows_reg      <= ROWS_RST;
            cols_reg      <= COLS_RST;
            birth_reg     <= BIRTH_RST;
            survive_reg   <= SURVIVE_RST;
            row_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            row_cnt_reg   <= '0;
            col_cnt_reg   <= '0;
            op_reg        <= OP_NONE;
        end
        else
        begin
            state_reg     <= state_next;
            rows_reg      <= rows_next;
            cols_reg      <= cols_next;
            birth_reg     <= birth_next;
            survive_reg   <= survive_next;
            row_valid_reg <= row_valid_next;
            rd_valid_reg  <= row_valid_reg[ram_raddr];
            out_valid_reg <= out_valid_next;
            row_cnt_reg   <= row_cnt_next;
            col_cnt_reg   <= col_cnt_next;
            op_reg        <= op_next;
        end
    end

    always_ff @(posedge clk)
    begin
        row_reg        <= row_next;
        col_reg        <= col_next;
        val_reg        <= val_next;
        above_reg      <= above_next;
        middle_reg     <= middle_next;
        below_reg      <= below_next;
        first_reg      <= first_next;
        new_reg        <= new_next;
        res_alive_reg  <= res_alive_next;
        res_status_reg <= res_status_next;
        alive_out_reg  <= alive_out_next;
        status_out_reg <= status_out_next;
    end

    assign out_valid  = out_valid_reg;
    assign cell_alive = alive_out_reg;
    assign status     = status_out_reg;

`ifndef SYNTH
    a_col_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_G_CELL) |-> (SIZE_W'(col_cnt_reg) < nc))
        else $error("column counter beyond configured grid");

    a_row_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_G_WR) |-> (row_cnt_ext < nr))
        else $error("row counter beyond configured grid");

    a_write_steps: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> ((state_reg == S_C_MOD) || (state_reg == S_G_WR)))
        else $error("grid written outside a write step");

    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && (state_reg == S_G_WR) && (row_cnt_ext + SIZE_W'(2) < nr))
            |-> (ram_raddr != ram_waddr))
        else $error("generation reads the row it is writing");

    a_beat_starts_work: assert property (@(posedge clk) disable iff (!rst_n)
        in_beat |=> (state_reg != S_IDLE))
        else $error("input beat taken without starting work");
`endif

endmodule

>>> src/llas_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module llas_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> src/llas_rule.sv
// Shared cell-rule unit: next state of one cell from three buffered rows.
// Depends on llas_pkg.
module llas_rule (
    input  llas_pkg::nbhd_t                   rows,
    input  logic [llas_pkg::COL_W-1:0]        col,
    input  logic [llas_pkg::SIZE_W-1:0]       ncols,
    input  llas_pkg::rule_mask_t              masks,
    output logic                              next_alive
);
    import llas_pkg::*;

    logic [COL_W-1:0]  col_l;
    logic [COL_W-1:0]  col_r;
    logic [SIZE_W-1:0] col_inc;
    logic [7:0]        nbrs;
    logic [CNT_W-1:0]  count;
    logic              self_alive;
    logic [MASK_W-1:0] mask;

    // Wrap at the configured column count, not at the storage width.
    assign col_inc = SIZE_W'(col) + SIZE_W'(1);
    assign col_l   = (col == '0) ? COL_W'(ncols - SIZE_W'(1)) : col - COL_W'(1);
    assign col_r   = (col_inc == ncols) ? '0 : COL_W'(col_inc);

    assign nbrs = {rows.above[col_l], rows.above[col], rows.above[col_r],
                   rows.middle[col_l], rows.middle[col_r],
                   rows.below[col_l], rows.below[col], rows.below[col_r]};

    assign self_alive = rows.middle[col];

    always_comb
    begin
        count = '0;
        for (int i = 0; i < 8; i++)
        begin
            count = count + CNT_W'(nbrs[i]);
        end
    end

    assign mask       = self_alive ? masks.survive : masks.birth;
    assign next_alive = (count != '0) && mask[count];

endmodule
